[hw/rtl/tat_pkg.sv]
`default_nettype none
package tat_pkg;

    localparam int CORDIC_N = 24;
    localparam int SQRT_N   = 32;
    // a/b delay line taps: one per stage from input register through divide stage
    localparam int AB_DEPTH = 1 + CORDIC_N + 3 + SQRT_N + CORDIC_N + 1;

    localparam logic signed [31:0] CORDIC_K = 32'sd652032874;
    localparam logic signed [31:0] UDEG_PER_MDEG = 32'sd1000;

    localparam logic [25:0] ATAN_UDEG [CORDIC_N] = '{
        26'd45000000, 26'd26565051, 26'd14036243, 26'd7125016, 26'd3576334, 26'd1789911,
        26'd895174,   26'd447614,   26'd223811,   26'd111906,  26'd55953,   26'd27976,
        26'd13988,    26'd6994,     26'd3497,     26'd1749,    26'd874,     26'd437,
        26'd219,      26'd109,      26'd55,       26'd27,      26'd14,      26'd7
    };

    // floor(v / 1000) = (v * DIV_M) >> DIV_SHIFT for v < 2^27
    localparam logic [27:0] DIV_M      = 28'd137438954;
    localparam int          DIV_SHIFT  = 37;
    localparam logic [26:0] ROUND_HALF = 27'd500;
    localparam logic [16:0] TILT_MAX   = 17'd90000;

    localparam int   APB_AW       = 3;
    localparam int   REG_IDX_BIT  = 2;
    localparam logic REG_OFFSET_A = 1'b0;
    localparam logic REG_OFFSET_B = 1'b1;
    localparam logic signed [15:0] OFFSET_A_RST = 16'sd1300;
    localparam logic signed [15:0] OFFSET_B_RST = 16'sd700;

    typedef struct packed {
        logic signed [15:0] offset_a;
        logic signed [15:0] offset_b;
    } t_cfg;

endpackage
`default_nettype wire

[hw/rtl/tat_in_if.sv]
`default_nettype none
interface tat_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] raw_word;

    modport source (output valid, output raw_word, input ready);
    modport sink   (input valid, input raw_word, output ready);
endinterface
`default_nettype wire

[hw/rtl/tat_out_if.sv]
`default_nettype none
interface tat_out_if;
    logic               valid;
    logic               ready;
    logic signed [16:0] angle_a;
    logic signed [16:0] angle_b;
    logic        [16:0] tilt;

    modport source (output valid, output angle_a, output angle_b, output tilt, input ready);
    modport sink   (input valid, input angle_a, input angle_b, input tilt, output ready);
endinterface
`default_nettype wire

[hw/rtl/tat_regs.sv]
`default_nettype none
module tat_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [tat_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output tat_pkg::t_cfg              o_cfg
);
    import tat_pkg::*;

    t_cfg r_cfg;
    logic sel;

    assign sel    = paddr[REG_IDX_BIT];
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.offset_a <= OFFSET_A_RST;
            r_cfg.offset_b <= OFFSET_B_RST;
        end else if (psel && penable && pwrite) begin
            unique case (sel)
                REG_OFFSET_A: r_cfg.offset_a <= pwdata[15:0];
                REG_OFFSET_B: r_cfg.offset_b <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (sel)
            REG_OFFSET_A: prdata = 32'(r_cfg.offset_a);
            REG_OFFSET_B: prdata = 32'(r_cfg.offset_b);
            default:      prdata = '0;
        endcase
    end
endmodule
`default_nettype wire

[hw/rtl/tat_sincos.sv]
`default_nettype none
module tat_sincos (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic signed [31:0] i_z,
    output logic               o_valid,
    output logic signed [31:0] o_sin,
    output logic signed [31:0] o_cos
);
    import tat_pkg::*;

    logic signed [31:0] r_x [CORDIC_N];
    logic signed [31:0] r_y [CORDIC_N];
    logic signed [31:0] r_z [CORDIC_N];
    logic [CORDIC_N-1:0] r_vld;

    for (genvar k = 0; k < CORDIC_N; k++) begin : g_stage
        logic signed [31:0] x_in, y_in, z_in, n_x, n_y, n_z, ang;
        if (k == 0) begin : g_first
            assign x_in = CORDIC_K;
            assign y_in = '0;
            assign z_in = i_z;
        end else begin : g_next
            assign x_in = r_x[k-1];
            assign y_in = r_y[k-1];
            assign z_in = r_z[k-1];
        end
        assign ang = 32'(ATAN_UDEG[k]);
        always_comb begin
            if (!z_in[31]) begin
                n_x = x_in - (y_in >>> k);
                n_y = y_in + (x_in >>> k);
                n_z = z_in - ang;
            end else begin
                n_x = x_in + (y_in >>> k);
                n_y = y_in - (x_in >>> k);
                n_z = z_in + ang;
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[k] <= n_x;
                r_y[k] <= n_y;
                r_z[k] <= n_z;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[CORDIC_N-2:0], i_valid};
        end
    end

    assign o_valid = r_vld[CORDIC_N-1];
    assign o_sin   = r_y[CORDIC_N-1];
    assign o_cos   = r_x[CORDIC_N-1];
endmodule
`default_nettype wire

[hw/rtl/tat_isqrt.sv]
`default_nettype none
module tat_isqrt (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [63:0]        i_v,
    input  logic signed [31:0] i_x,
    output logic               o_valid,
    output logic [31:0]        o_root,
    output logic signed [31:0] o_x
);
    import tat_pkg::*;

    logic [63:0]        r_rem [SQRT_N];
    logic [63:0]        r_res [SQRT_N];
    logic signed [31:0] r_x   [SQRT_N];
    logic [SQRT_N-1:0]  r_vld;

    for (genvar k = 0; k < SQRT_N; k++) begin : g_stage
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
        logic [63:0] rem_in, res_in, trial, n_rem, n_res;
        logic signed [31:0] x_in;
        if (k == 0) begin : g_first
            assign rem_in = i_v;
            assign res_in = '0;
            assign x_in   = i_x;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign res_in = r_res[k-1];
            assign x_in   = r_x[k-1];
        end
        assign trial = res_in + BIT;
        always_comb begin
            if (rem_in >= trial) begin
                n_rem = rem_in - trial;
                n_res = (res_in >> 1) + BIT;
            end else begin
                n_rem = rem_in;
                n_res = res_in >> 1;
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_rem;
                r_res[k] <= n_res;
                r_x[k]   <= x_in;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[SQRT_N-2:0], i_valid};
        end
    end

    assign o_valid = r_vld[SQRT_N-1];
    assign o_root  = r_res[SQRT_N-1][31:0];
    assign o_x     = r_x[SQRT_N-1];
endmodule
`default_nettype wire

[hw/rtl/tat_atan2.sv]
`default_nettype none
module tat_atan2 (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [31:0]        i_y,
    input  logic signed [31:0] i_x,
    output logic               o_valid,
    output logic signed [31:0] o_z
);
    import tat_pkg::*;

    logic signed [33:0] r_x [CORDIC_N];
    logic signed [33:0] r_y [CORDIC_N];
    logic signed [31:0] r_z [CORDIC_N];
    logic [CORDIC_N-1:0] r_vld;

    for (genvar k = 0; k < CORDIC_N; k++) begin : g_stage
        logic signed [33:0] x_in, y_in, n_x, n_y;
        logic signed [31:0] z_in, n_z, ang;
        if (k == 0) begin : g_first
            assign x_in = 34'(i_x);
            assign y_in = signed'({2'b00, i_y});
            assign z_in = '0;
        end else begin : g_next
            assign x_in = r_x[k-1];
            assign y_in = r_y[k-1];
            assign z_in = r_z[k-1];
        end
        assign ang = 32'(ATAN_UDEG[k]);
        always_comb begin
            if (!y_in[33] && (y_in != '0)) begin
                n_x = x_in + (y_in >>> k);
                n_y = y_in - (x_in >>> k);
                n_z = z_in + ang;
            end else begin
                n_x = x_in - (y_in >>> k);
                n_y = y_in + (x_in >>> k);
                n_z = z_in - ang;
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[k] <= n_x;
                r_y[k] <= n_y;
                r_z[k] <= n_z;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[CORDIC_N-2:0], i_valid};
        end
    end

    assign o_valid = r_vld[CORDIC_N-1];
    assign o_z     = r_z[CORDIC_N-1];
endmodule
`default_nettype wire

[hw/rtl/two_axis_inclinometer_tilt.sv]
// Channel   Dir  Handshake          Payload
// i_in      in   valid/ready        raw_word[31:0]  (A = [31:16], B = [15:0])
// o_res     out  valid/ready        angle_a[16:0], angle_b[16:0], tilt[16:0]
// APB       in   psel/penable, pready=1   offset_a @0x0, offset_b @0x4
//
// One transaction accepted per cycle while the pipeline is not stalled; the result
// passes through the 86-stage pipeline (24 + 24 CORDIC, 32 sqrt stages).
// Stall: the whole pipeline freezes when the output register is full and not
// taken; i_in.ready = output free or being taken.
// Reset (i_rst_n low, synchronous) clears all valid bits and loads the offsets.
`default_nettype none
module two_axis_inclinometer_tilt (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    tat_in_if.sink                     i_in,
    tat_out_if.source                  o_res,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [tat_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import tat_pkg::*;

    t_cfg cfg;
    logic en;

    // stage 0: offset subtract, scale to microdegrees
    logic signed [16:0] n_a, n_b;
    logic signed [31:0] r_za, r_zb;
    logic               r_v0;
    logic [33:0]        r_ab [AB_DEPTH];

    // CORDIC sin/cos
    logic               va, vb;
    logic signed [31:0] sa, ca, sb, cb;

    // products, squares, sum
    logic signed [63:0] prod_p, prod_q, prod_x;
    logic signed [31:0] n_xr;
    logic signed [31:0] r_p, r_q, r_xm, r_xs, r_xsum;
    logic signed [63:0] sq_p, sq_q;
    logic [63:0]        r_pp, r_qq, r_sum;
    logic               r_vm, r_vs, r_vsum;

    // sqrt, atan2
    logic               v_sq, v_at;
    logic [31:0]        mag;
    logic signed [31:0] xr, z;

    // rounding divide by 1000
    logic [26:0]        n_v;
    logic [54:0]        r_prod;
    logic               r_vd;
    logic [17:0]        quo;

    // output register
    logic               r_out_valid;
    logic signed [16:0] r_out_a, r_out_b;
    logic [16:0]        r_out_t;

    tat_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // global advance: output slot free or being drained
    assign en          = !r_out_valid || o_res.ready;
    assign i_in.ready  = en;

    assign n_a = 17'(signed'(i_in.raw_word[31:16])) - 17'(cfg.offset_a);
    assign n_b = 17'(signed'(i_in.raw_word[15:0]))  - 17'(cfg.offset_b);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_za     <= 32'(n_a) * UDEG_PER_MDEG;
            r_zb     <= 32'(n_b) * UDEG_PER_MDEG;
            r_ab[0]  <= {n_a, n_b};
        end
    end

    // a/b ride along beside the math
    for (genvar k = 1; k < AB_DEPTH; k++) begin : g_ab
        always_ff @(posedge i_clk) begin
            if (en) r_ab[k] <= r_ab[k-1];
        end
    end

    tat_sincos u_sc_a (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en), .i_valid (r_v0),
        .i_z (r_za), .o_valid (va), .o_sin (sa), .o_cos (ca)
    );

    tat_sincos u_sc_b (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en), .i_valid (r_v0),
        .i_z (r_zb), .o_valid (vb), .o_sin (sb), .o_cos (cb)
    );

    // Q30 products, floored back to Q30
    assign prod_p = 64'(sa) * 64'(cb);
    assign prod_q = 64'(sb) * 64'(ca);
    assign prod_x = 64'(ca) * 64'(cb);
    always_comb begin
        n_xr = 32'(prod_x >>> 30);
        if (n_xr < 32'sd1) n_xr = 32'sd1;
    end

    assign sq_p = 64'(r_p) * 64'(r_p);
    assign sq_q = 64'(r_q) * 64'(r_q);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p    <= 32'(prod_p >>> 30);
            r_q    <= 32'(prod_q >>> 30);
            r_xm   <= n_xr;
            r_pp   <= $unsigned(sq_p);
            r_qq   <= $unsigned(sq_q);
            r_xs   <= r_xm;
            r_sum  <= r_pp + r_qq;
            r_xsum <= r_xs;
        end
    end

    tat_isqrt u_sqrt (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en), .i_valid (r_vsum),
        .i_v (r_sum), .i_x (r_xsum), .o_valid (v_sq), .o_root (mag), .o_x (xr)
    );

    tat_atan2 u_atan (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en), .i_valid (v_sq),
        .i_y (mag), .i_x (xr), .o_valid (v_at), .o_z (z)
    );

    // negative residue clamps to zero, then add half for rounding
    assign n_v = z[31] ? ROUND_HALF : (z[26:0] + ROUND_HALF);
    assign quo = 18'(r_prod >> DIV_SHIFT);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_prod  <= 55'(n_v) * 55'(DIV_M);
            r_out_a <= signed'(r_ab[AB_DEPTH-1][33:17]);
            r_out_b <= signed'(r_ab[AB_DEPTH-1][16:0]);
            r_out_t <= (quo > 18'(TILT_MAX)) ? TILT_MAX : quo[16:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0        <= 1'b0;
            r_vm        <= 1'b0;
            r_vs        <= 1'b0;
            r_vsum      <= 1'b0;
            r_vd        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_v0        <= i_in.valid;
            r_vm        <= va && vb;
            r_vs        <= r_vm;
            r_vsum      <= r_vs;
            r_vd        <= v_at;
            r_out_valid <= r_vd;
        end
    end

    assign o_res.valid   = r_out_valid;
    assign o_res.angle_a = r_out_a;
    assign o_res.angle_b = r_out_b;
    assign o_res.tilt    = r_out_t;
endmodule
`default_nettype wire

[hw/rtl/tat_chk.sv]
`default_nettype none
module tat_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [16:0] i_tilt
);
    import tat_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_tilt))
        else $error("result changed while stalled");

    a_tilt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_tilt <= TILT_MAX)
        else $error("tilt above 90 degrees");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_ready_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready == (!i_out_valid || i_out_ready))
        else $error("input ready does not follow output slot");

    a_in_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready || !i_in_valid)
        else $error("input stalled with empty output");
endmodule

bind two_axis_inclinometer_tilt tat_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_tilt      (o_res.tilt)
);
`default_nettype wire

[tb/sv/tat_tb_checker.sv]
`timescale 1ns / 1ps
module tat_tb_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    tat_in_if     in_ch,
    tat_out_if    res_ch,
    output int    o_errors,
    output int    o_pending
);
    import tat_pkg::*;

    typedef struct {
        logic signed [16:0] angle_a;
        logic signed [16:0] angle_b;
        logic        [16:0] tilt;
    } t_tilt_res;

    t_tilt_res tilt_q[$];
    logic signed [15:0] off_a = OFFSET_A_RST;
    logic signed [15:0] off_b = OFFSET_B_RST;

    function automatic longint floor_shr(longint v, int s);
        if (v >= 0) return v >>> s;
        return -(((-v) - 1) >>> s) - 1;
    endfunction

    function automatic void rotate(longint ang, output longint s, output longint c);
        longint x, y, z, dx, dy;
        x = CORDIC_K; y = 0; z = ang;
        for (int i = 0; i < CORDIC_N; i++) begin
            dx = floor_shr(y, i); dy = floor_shr(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(ATAN_UDEG[i]);
            end else begin
                x += dx; y -= dy; z += longint'(ATAN_UDEG[i]);
            end
        end
        s = y; c = x;
    endfunction

    function automatic longint int_sqrt(logic [63:0] v);
        logic [63:0] r, b;
        r = 0; b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b; r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic t_tilt_res tilt_of(logic [31:0] w);
        t_tilt_res r;
        longint a, b, sa, ca, sb, cb, p, q, xr, y, z, dx, dy;
        logic [63:0] sum;
        a = longint'($signed(w[31:16])) - longint'(off_a);
        b = longint'($signed(w[15:0])) - longint'(off_b);
        rotate(a * 1000, sa, ca);
        rotate(b * 1000, sb, cb);
        p = floor_shr(sa * cb, 30);
        q = floor_shr(sb * ca, 30);
        xr = floor_shr(ca * cb, 30);
        if (xr < 1) xr = 1;
        sum = 64'(p * p) + 64'(q * q);
        y = int_sqrt(sum);
        z = 0;
        // vectoring pass: atan2(mag, xr)
        for (int i = 0; i < CORDIC_N; i++) begin
            dx = floor_shr(y, i); dy = floor_shr(xr, i);
            if (y > 0) begin
                xr += dx; y -= dy; z += longint'(ATAN_UDEG[i]);
            end else begin
                xr -= dx; y += dy; z -= longint'(ATAN_UDEG[i]);
            end
        end
        if (z < 0) z = 0;
        z = (z + 500) / 1000;
        if (z > 90000) z = 90000;
        r.angle_a = a[16:0]; r.angle_b = b[16:0]; r.tilt = z[16:0];
        return r;
    endfunction

    // offsets come from the top through this call
    function automatic void set_offset(logic idx, logic [15:0] v);
        if (idx == REG_OFFSET_A) off_a = v;
        else off_b = v;
    endfunction

    initial o_errors = 0;
    assign o_pending = tilt_q.size();

    always @(posedge i_clk) begin
        t_tilt_res e;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) tilt_q.push_back(tilt_of(in_ch.raw_word));
            if (res_ch.valid && res_ch.ready) begin
                if (tilt_q.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10) $display("unexpected result transaction");
                end else begin
                    e = tilt_q.pop_front();
                    if (e.angle_a !== res_ch.angle_a || e.angle_b !== res_ch.angle_b
                        || e.tilt !== res_ch.tilt) begin
                        o_errors++;
                        if (o_errors <= 10)
                            $display("mismatch exp a=%0d b=%0d t=%0d got a=%0d b=%0d t=%0d",
                                     e.angle_a, e.angle_b, e.tilt, res_ch.angle_a,
                                     res_ch.angle_b, res_ch.tilt);
                    end
                end
            end
        end
    end
endmodule

[tb/sv/two_axis_inclinometer_tilt_tb.sv]
`timescale 1ns / 1ps
module two_axis_inclinometer_tilt_tb;
    import tat_pkg::*;

    localparam int LATENCY  = 90;
    localparam int WATCHDOG = 20000;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [APB_AW-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    int errors, pending, idle_cycles;
    int hold_off;   // >0: sink holds ready low for that many cycles
    bit timed_out;

    tat_in_if  in_ch();
    tat_out_if res_ch();

    two_axis_inclinometer_tilt dut (
        .i_clk, .i_rst_n, .i_in(in_ch), .o_res(res_ch),
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    tat_tb_checker chk (
        .i_clk, .i_rst_n, .in_ch, .res_ch, .o_errors(errors), .o_pending(pending)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        in_ch.valid = 0;
        in_ch.raw_word = '0;
        res_ch.ready = 0;
        hold_off = 0;
    end

    // Random gap: mostly short, occasionally long.
    function automatic int gap_len();
        if ($urandom_range(0, 3) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        return $urandom_range(0, 3);
    endfunction

    // Result sink: random stalls, plus explicit long hold-offs.
    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            res_ch.ready <= 0;
        end else begin
            res_ch.ready <= ($urandom_range(0, 2) != 0);
        end
    end

    // Watchdog: cycles with no transaction on either channel.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic reg_write(logic idx, logic [15:0] v);
        @(negedge i_clk);
        psel <= 1; pwrite <= 1; penable <= 0;
        paddr <= APB_AW'(idx) << REG_IDX_BIT;
        pwdata <= {16'($urandom_range(0, 65535)), v};
        @(negedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        chk.set_offset(idx, v);
        @(negedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    // One input transaction, with an optional gap before it.
    // valid stays high after the accept so words can go back to back.
    task automatic send_word(logic [31:0] w, int gap);
        if (gap > 0) begin
            @(negedge i_clk);
            in_ch.valid <= 0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_ch.valid <= 1;
        in_ch.raw_word <= w;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic drain();
        @(negedge i_clk);
        in_ch.valid <= 0;
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    task automatic random_words(int n);
        logic [31:0] w;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 3))
                0: w = $urandom();
                // realistic small angles around zero
                1: w = {16'($signed($urandom_range(0, 20000)) - 10000),
                        16'($signed($urandom_range(0, 20000)) - 10000)};
                2: w = {16'($urandom_range(0, 1) ? 16'h7FFF : 16'h8000), 16'($urandom())};
                default: w = {16'($urandom()), 16'($urandom_range(0, 1) ? 16'h7FFF : 16'h8000)};
            endcase
            send_word(w, gap_len());
        end
    endtask

    logic [15:0] edge_vals[6] = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0514, 16'h02BC};

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // directed: reset offsets, field extremes on both axes
        foreach (edge_vals[i])
            send_word({edge_vals[i], edge_vals[(i + 2) % 6]}, 0);
        send_word(32'hFFFF_FFFF, 0);
        send_word(32'h0000_0000, 1);
        send_word(32'h2710_D8F0, 0);   // +10 deg / -10 deg
        drain();

        // offset extremes: drive the differences to +-65535
        reg_write(REG_OFFSET_A, 16'h8000);
        reg_write(REG_OFFSET_B, 16'h7FFF);
        foreach (edge_vals[i]) send_word({edge_vals[i], edge_vals[i]}, 0);
        drain();
        reg_write(REG_OFFSET_A, 16'h7FFF);
        reg_write(REG_OFFSET_B, 16'h8000);
        foreach (edge_vals[i]) send_word({edge_vals[i], edge_vals[5 - i]}, 0);
        drain();

        // zero offsets; long sink stall while the source keeps pushing
        reg_write(REG_OFFSET_A, 16'h0000);
        reg_write(REG_OFFSET_B, 16'h0000);
        @(negedge i_clk);
        hold_off = 300;
        random_words(200);
        // source pauses until everything is back
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            reg_write(REG_OFFSET_A, 16'($urandom()));
            reg_write(REG_OFFSET_B, 16'($urandom()));
            random_words(250);
            drain();
        end

        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
